### hw/rtl/spm_pkg.sv
package spm_pkg;

    // depth fraction bits and default rotation stage count
    localparam int FRAC_BITS     = 12;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_COUNT    = 30;

    // angle widths: summed angle in degrees with 24 fraction bits, residual after reduction
    localparam int ANG_W = 36;
    localparam int RES_W = 33;

    localparam logic signed [ANG_W-1:0] ANG_FULL    = 36'sd6039797760;
    localparam logic signed [ANG_W-1:0] ANG_HALF    = 36'sd3019898880;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = 36'sd1509949440;

    // 1/K gain in Q1.30
    localparam logic signed [RES_W-1:0] CORDIC_X0 = 33'sd652032874;

    // arctangent of 2^-i in degrees, 24 fraction bits
    localparam logic signed [RES_W-1:0] ATAN_DEG24 [ATAN_COUNT] = '{
        33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938, 33'sd60000934,
        33'sd30029717,  33'sd15018523,  33'sd7509720,   33'sd3754917,   33'sd1877466,
        33'sd938734,    33'sd469367,    33'sd234684,    33'sd117342,    33'sd58671,
        33'sd29335,     33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
        33'sd917,       33'sd458,       33'sd229,       33'sd115,       33'sd57,
        33'sd29,        33'sd14,        33'sd7,         33'sd4,         33'sd2
    };

    // depth: M = layer*1000*2^16 + 5000 + floor((y+h)*2^16 / 2^FRAC_BITS), z = floor(M/10000)
    localparam int ZM_W = 50;
    localparam logic signed [ZM_W-1:0] LAYER_SCALE = 50'sd65536000;
    localparam logic signed [ZM_W-1:0] LAYER_BIAS  = 50'sd5000;
    // 10000 * 2^21: the depth range edge
    localparam logic signed [ZM_W-1:0] Z_LIM       = 50'sd20971520000;
    // after dropping 4 bits the divisor is 625, done by reciprocal and one correction
    localparam logic [22:0]            Z_RECIP     = 23'd6871947;
    localparam logic [33:0]            Z_DIV       = 34'd625;
    localparam logic signed [21:0]     Z_HI        = 22'sd2097151;
    localparam logic signed [21:0]     Z_LO        = -22'sd2097152;

    localparam logic signed [47:0] SAT_HI = 48'sd2147483647;
    localparam logic signed [47:0] SAT_LO = -48'sd2147483648;

    typedef enum logic [1:0] {
        ZS_NONE = 2'd0,
        ZS_HI   = 2'd1,
        ZS_LO   = 2'd2
    } t_zsat;

    // one CORDIC rotation: cos, sin (Q1.30) and residual angle
    typedef struct packed {
        logic signed [RES_W-1:0] x;
        logic signed [RES_W-1:0] y;
        logic signed [RES_W-1:0] a;
    } t_rot;

    // beat traveling down the cell chain
    typedef struct packed {
        t_rot                own;
        t_rot                par;
        t_rot                tot;
        logic                neg_own;
        logic                neg_par;
        logic                neg_tot;
        logic signed [31:0]  px;
        logic signed [31:0]  py;
        logic signed [31:0]  ppx;
        logic signed [31:0]  ppy;
        logic [30:0]         sx;
        logic [30:0]         sy;
        logic [30:0]         psx;
        logic [30:0]         psy;
        logic [31:0]         zm;
        t_zsat               zsat;
    } t_cdata;

    // one micro-rotation, direction from the residual sign (zero turns positive)
    function automatic t_rot cordic_step(input t_rot v, input int sh,
                                         input logic signed [RES_W-1:0] at);
        t_rot n;
        if (v.a >= 0) begin
            n.x = v.x - (v.y >>> sh);
            n.y = v.y + (v.x >>> sh);
            n.a = v.a - at;
        end else begin
            n.x = v.x + (v.y >>> sh);
            n.y = v.y - (v.x >>> sh);
            n.a = v.a + at;
        end
        return n;
    endfunction

endpackage

### hw/rtl/sprite_model_matrix_unit.sv
// Sprite model matrix unit: takes one sprite (position, size, rotation, layer and an
// optional parent transform) per beat and returns the nonzero model matrix entries in
// Q20.12 (depth in Q6.16), saturated. It is fully pipelined and accepts one beat every
// clock while the output is not stalled. The prep stages feed the row of CORDIC cells,
// one rotation step per cell for the own, parent and summed angles side by side, which
// feeds the post stages. Each stage holds its beat under back-pressure and empty stages
// still fill, so input is taken while a finished result waits, if some stage is empty.
module sprite_model_matrix_unit #(
    parameter int CORDIC_STAGES = spm_pkg::CORDIC_STAGES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [30:0]        i_size_x,
    input  logic [30:0]        i_size_y,
    input  logic signed [25:0] i_rot_deg,
    input  logic signed [7:0]  i_layer,
    input  logic               i_parent_present,
    input  logic signed [31:0] i_parent_pos_x,
    input  logic signed [31:0] i_parent_pos_y,
    input  logic [30:0]        i_parent_size_x,
    input  logic [30:0]        i_parent_size_y,
    input  logic signed [25:0] i_parent_rot_deg,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_m00,
    output logic signed [31:0] o_m10,
    output logic signed [31:0] o_m01,
    output logic signed [31:0] o_m11,
    output logic signed [31:0] o_trans_x,
    output logic signed [31:0] o_trans_y,
    output logic signed [21:0] o_trans_z
);

    spm_pkg::t_cdata      chain_data  [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0] chain_valid;
    logic [CORDIC_STAGES:0] chain_ready;

    // angle reduction and depth numerator
    spm_prep u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_size_x         (i_size_x),
        .i_size_y         (i_size_y),
        .i_rot_deg        (i_rot_deg),
        .i_layer          (i_layer),
        .i_parent_present (i_parent_present),
        .i_parent_pos_x   (i_parent_pos_x),
        .i_parent_pos_y   (i_parent_pos_y),
        .i_parent_size_x  (i_parent_size_x),
        .i_parent_size_y  (i_parent_size_y),
        .i_parent_rot_deg (i_parent_rot_deg),
        .o_valid          (chain_valid[0]),
        .i_ready          (chain_ready[0]),
        .o_data           (chain_data[0])
    );

    // row of rotation cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        spm_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    // products, translation and output register
    spm_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (chain_valid[CORDIC_STAGES]),
        .o_ready   (chain_ready[CORDIC_STAGES]),
        .i_data    (chain_data[CORDIC_STAGES]),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_m00     (o_m00),
        .o_m10     (o_m10),
        .o_m01     (o_m01),
        .o_m11     (o_m11),
        .o_trans_x (o_trans_x),
        .o_trans_y (o_trans_y),
        .o_trans_z (o_trans_z)
    );

endmodule

### hw/rtl/spm_prep.sv
module spm_prep (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [31:0]     i_pos_x,
    input  logic signed [31:0]     i_pos_y,
    input  logic [30:0]            i_size_x,
    input  logic [30:0]            i_size_y,
    input  logic signed [25:0]     i_rot_deg,
    input  logic signed [7:0]      i_layer,
    input  logic                   i_parent_present,
    input  logic signed [31:0]     i_parent_pos_x,
    input  logic signed [31:0]     i_parent_pos_y,
    input  logic [30:0]            i_parent_size_x,
    input  logic [30:0]            i_parent_size_y,
    input  logic signed [25:0]     i_parent_rot_deg,
    output logic                   o_valid,
    input  logic                   i_ready,
    output spm_pkg::t_cdata        o_data
);

    localparam int AW = spm_pkg::ANG_W;
    localparam int RW = spm_pkg::RES_W;
    localparam int MW = spm_pkg::ZM_W;

    // bring any summed angle into [-180, 180)
    function automatic logic signed [RW-1:0] reduce(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        if (a >= spm_pkg::ANG_HALF + 2 * spm_pkg::ANG_FULL)
            r = a - 3 * spm_pkg::ANG_FULL;
        else if (a >= spm_pkg::ANG_HALF + spm_pkg::ANG_FULL)
            r = a - 2 * spm_pkg::ANG_FULL;
        else if (a >= spm_pkg::ANG_HALF)
            r = a - spm_pkg::ANG_FULL;
        else if (a < -spm_pkg::ANG_HALF - 2 * spm_pkg::ANG_FULL)
            r = a + 3 * spm_pkg::ANG_FULL;
        else if (a < -spm_pkg::ANG_HALF - spm_pkg::ANG_FULL)
            r = a + 2 * spm_pkg::ANG_FULL;
        else if (a < -spm_pkg::ANG_HALF)
            r = a + spm_pkg::ANG_FULL;
        else
            r = a;
        return r[RW-1:0];
    endfunction

    // fold into [-90, 90]; the far half flips cos and sin at the end
    function automatic logic is_far(input logic signed [RW-1:0] a);
        return (AW'(a) > spm_pkg::ANG_QUARTER) || (AW'(a) < -spm_pkg::ANG_QUARTER);
    endfunction

    function automatic spm_pkg::t_rot start_rot(input logic signed [RW-1:0] a);
        spm_pkg::t_rot        v;
        logic signed [AW-1:0] f;
        if (AW'(a) > spm_pkg::ANG_QUARTER)
            f = AW'(a) - spm_pkg::ANG_HALF;
        else if (AW'(a) < -spm_pkg::ANG_QUARTER)
            f = AW'(a) + spm_pkg::ANG_HALF;
        else
            f = AW'(a);
        v.x = spm_pkg::CORDIC_X0;
        v.y = '0;
        v.a = f[RW-1:0];
        return v;
    endfunction

    logic [2:0] r_v;
    logic [2:0] rdy;
    logic [2:0] vin;
    logic [2:0] ld;

    // stage 0: angles in 24-bit fraction degrees, parent masked
    logic signed [AW-1:0] r0_ao, r0_ap, r0_at;
    logic signed [31:0]   r0_px, r0_py, r0_ppx, r0_ppy;
    logic [30:0]          r0_sx, r0_sy, r0_psx, r0_psy;
    logic signed [MW-1:0] r0_lz;
    logic signed [33:0]   r0_zs;
    logic signed [AW-1:0] n0_ao, n0_ap, n0_at;
    logic signed [MW-1:0] n0_lz;
    logic signed [33:0]   n0_zs;

    // stage 1: reduced angles, depth numerator
    logic signed [RW-1:0] r1_ao, r1_ap, r1_at;
    logic signed [31:0]   r1_px, r1_py, r1_ppx, r1_ppy;
    logic [30:0]          r1_sx, r1_sy, r1_psx, r1_psy;
    logic signed [MW-1:0] r1_m;
    logic signed [MW-1:0] n1_m;

    // stage 2: chain entry beat
    spm_pkg::t_cdata      r2_d;
    spm_pkg::t_cdata      n2_d;
    logic signed [MW-1:0] zofs;

    // handshake ripple
    always_comb begin
        rdy[2] = ~r_v[2] | i_ready;
        rdy[1] = ~r_v[1] | rdy[2];
        rdy[0] = ~r_v[0] | rdy[1];
        vin    = {r_v[1:0], i_valid};
        ld     = rdy & vin;
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[2];
    assign o_data  = r2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~rdy) | (vin & rdy);
        end
    end

    // stage 0 logic
    always_comb begin
        n0_ao = {{2{i_rot_deg[25]}}, i_rot_deg, 8'd0};
        n0_ap = i_parent_present ? {{2{i_parent_rot_deg[25]}}, i_parent_rot_deg, 8'd0} : '0;
        n0_at = n0_ao + n0_ap;
        n0_lz = MW'(i_layer) * spm_pkg::LAYER_SCALE + spm_pkg::LAYER_BIAS;
        n0_zs = 34'(i_pos_y) + $signed({3'b0, i_size_y});
    end

    // stage 1 logic
    assign n1_m = r0_lz + ((MW'(r0_zs) <<< 16) >>> spm_pkg::FRAC_BITS);

    // stage 2 logic
    always_comb begin
        zofs        = r1_m + spm_pkg::Z_LIM;
        n2_d.own    = start_rot(r1_ao);
        n2_d.par    = start_rot(r1_ap);
        n2_d.tot    = start_rot(r1_at);
        n2_d.neg_own = is_far(r1_ao);
        n2_d.neg_par = is_far(r1_ap);
        n2_d.neg_tot = is_far(r1_at);
        n2_d.px     = r1_px;
        n2_d.py     = r1_py;
        n2_d.ppx    = r1_ppx;
        n2_d.ppy    = r1_ppy;
        n2_d.sx     = r1_sx;
        n2_d.sy     = r1_sy;
        n2_d.psx    = r1_psx;
        n2_d.psy    = r1_psy;
        n2_d.zm     = zofs[35:4];
        if (r1_m >= spm_pkg::Z_LIM)
            n2_d.zsat = spm_pkg::ZS_HI;
        else if (r1_m < -spm_pkg::Z_LIM)
            n2_d.zsat = spm_pkg::ZS_LO;
        else
            n2_d.zsat = spm_pkg::ZS_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r0_ao  <= n0_ao;
            r0_ap  <= n0_ap;
            r0_at  <= n0_at;
            r0_px  <= i_pos_x;
            r0_py  <= i_pos_y;
            r0_sx  <= i_size_x;
            r0_sy  <= i_size_y;
            r0_ppx <= i_parent_present ? i_parent_pos_x : '0;
            r0_ppy <= i_parent_present ? i_parent_pos_y : '0;
            r0_psx <= i_parent_present ? i_parent_size_x : '0;
            r0_psy <= i_parent_present ? i_parent_size_y : '0;
            r0_lz  <= n0_lz;
            r0_zs  <= n0_zs;
        end
        if (ld[1]) begin
            r1_ao  <= reduce(r0_ao);
            r1_ap  <= reduce(r0_ap);
            r1_at  <= reduce(r0_at);
            r1_px  <= r0_px;
            r1_py  <= r0_py;
            r1_sx  <= r0_sx;
            r1_sy  <= r0_sy;
            r1_ppx <= r0_ppx;
            r1_ppy <= r0_ppy;
            r1_psx <= r0_psx;
            r1_psy <= r0_psy;
            r1_m   <= n1_m;
        end
        if (ld[2]) begin
            r2_d <= n2_d;
        end
    end

endmodule

### hw/rtl/spm_cell.sv
module spm_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  spm_pkg::t_cdata i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output spm_pkg::t_cdata o_data
);

    logic            r_valid;
    spm_pkg::t_cdata r_data;
    spm_pkg::t_cdata n_data;

    // one rotation step on all three angles, payload rides along
    always_comb begin
        n_data     = i_data;
        n_data.own = spm_pkg::cordic_step(i_data.own, IDX, spm_pkg::ATAN_DEG24[IDX]);
        n_data.par = spm_pkg::cordic_step(i_data.par, IDX, spm_pkg::ATAN_DEG24[IDX]);
        n_data.tot = spm_pkg::cordic_step(i_data.tot, IDX, spm_pkg::ATAN_DEG24[IDX]);
    end

    assign o_ready = ~r_valid | i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

### hw/rtl/spm_post.sv
module spm_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  spm_pkg::t_cdata    i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_m00,
    output logic signed [31:0] o_m10,
    output logic signed [31:0] o_m01,
    output logic signed [31:0] o_m11,
    output logic signed [31:0] o_trans_x,
    output logic signed [31:0] o_trans_y,
    output logic signed [21:0] o_trans_z
);

    localparam int CW = spm_pkg::RES_W;
    localparam int RW = 36;   // rounded size products
    localparam int VW = 37;   // pivot-corrected positions
    localparam int TW = 44;   // translation sums

    // round(p / 2^30), ties up
    function automatic logic signed [41:0] rnd30(input logic signed [71:0] p);
        logic signed [71:0] t;
        t = p + 72'sd536870912;
        return t[71:30];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > spm_pkg::SAT_HI)
            return 32'sh7FFFFFFF;
        else if (v < spm_pkg::SAT_LO)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic [7:0] r_v;
    logic [7:0] rdy;
    logic [7:0] vin;
    logic [7:0] ld;

    // stage 0: signed cos/sin, depth quotient estimate
    logic signed [CW-1:0] r0_co, r0_so, r0_cp, r0_sp, r0_ct, r0_st;
    logic signed [31:0]   r0_px, r0_py, r0_ppx, r0_ppy;
    logic [30:0]          r0_sx, r0_sy, r0_psx, r0_psy;
    logic [31:0]          r0_zm;
    spm_pkg::t_zsat       r0_zsat;
    logic [22:0]          r0_q0;
    logic [54:0]          n0_qp;

    // stage 1: cos/sin times sizes, depth done
    logic signed [64:0]   r1_p [12];
    logic signed [CW-1:0] r1_cp, r1_sp;
    logic signed [31:0]   r1_px, r1_py, r1_ppx, r1_ppy;
    logic [30:0]          r1_sx, r1_sy, r1_psx, r1_psy;
    logic signed [21:0]   r1_z;
    logic signed [64:0]   n1_p [12];
    logic [33:0]          n1_rem;
    logic [22:0]          n1_q;
    logic signed [21:0]   n1_z;

    // stage 2: rounded products
    logic signed [RW-1:0] r2_r [12];
    logic signed [CW-1:0] r2_cp, r2_sp;
    logic signed [31:0]   r2_px, r2_py, r2_ppx, r2_ppy;
    logic [30:0]          r2_sx, r2_sy, r2_psx, r2_psy;
    logic signed [21:0]   r2_z;
    logic signed [RW-1:0] n2_r [12];
    logic signed [41:0]   n2_t;

    // stage 3: linear part done, own and parent pivot terms
    logic signed [31:0]   r3_m00, r3_m10, r3_m01, r3_m11;
    logic signed [VW-1:0] r3_vx, r3_vy, r3_wx, r3_wy;
    logic signed [CW-1:0] r3_cp, r3_sp;
    logic signed [21:0]   r3_z;

    // stage 4: parent rotation, split partial products
    logic signed [54:0]   r4_hi [4];
    logic signed [48:0]   r4_lo [4];
    logic signed [VW-1:0] r4_wx, r4_wy;
    logic signed [31:0]   r4_m00, r4_m10, r4_m01, r4_m11;
    logic signed [21:0]   r4_z;

    // stage 5: rounded parent rotation
    logic signed [41:0]   r5_t [4];
    logic signed [VW-1:0] r5_wx, r5_wy;
    logic signed [31:0]   r5_m00, r5_m10, r5_m01, r5_m11;
    logic signed [21:0]   r5_z;

    // stage 6: doubled translation
    logic signed [TW-1:0] r6_tx, r6_ty;
    logic signed [31:0]   r6_m00, r6_m10, r6_m01, r6_m11;
    logic signed [21:0]   r6_z;
    logic signed [47:0]   n7_hx, n7_hy;

    // stage 7: output register
    logic signed [31:0]   r7_m00, r7_m10, r7_m01, r7_m11, r7_tx, r7_ty;
    logic signed [21:0]   r7_z;

    // handshake ripple
    always_comb begin
        rdy[7] = ~r_v[7] | i_ready;
        for (int k = 6; k >= 0; k--) begin
            rdy[k] = ~r_v[k] | rdy[k+1];
        end
        vin = {r_v[6:0], i_valid};
        ld  = rdy & vin;
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~rdy) | (vin & rdy);
        end
    end

    assign n0_qp = 55'(i_data.zm) * 55'(spm_pkg::Z_RECIP);

    // stage 1: 12 products; depth remainder correction
    always_comb begin
        n1_p[0]  = r0_ct * $signed({1'b0, r0_sx});
        n1_p[1]  = r0_st * $signed({1'b0, r0_sx});
        n1_p[2]  = r0_st * $signed({1'b0, r0_sy});
        n1_p[3]  = r0_ct * $signed({1'b0, r0_sy});
        n1_p[4]  = r0_co * $signed({1'b0, r0_sx});
        n1_p[5]  = r0_so * $signed({1'b0, r0_sy});
        n1_p[6]  = r0_so * $signed({1'b0, r0_sx});
        n1_p[7]  = r0_co * $signed({1'b0, r0_sy});
        n1_p[8]  = r0_cp * $signed({1'b0, r0_psx});
        n1_p[9]  = r0_sp * $signed({1'b0, r0_psy});
        n1_p[10] = r0_sp * $signed({1'b0, r0_psx});
        n1_p[11] = r0_cp * $signed({1'b0, r0_psy});
        n1_rem   = 34'(r0_zm) - 34'(r0_q0) * spm_pkg::Z_DIV;
        n1_q     = r0_q0 + 23'(n1_rem >= spm_pkg::Z_DIV);
        case (r0_zsat)
            spm_pkg::ZS_HI: n1_z = spm_pkg::Z_HI;
            spm_pkg::ZS_LO: n1_z = spm_pkg::Z_LO;
            default:        n1_z = {~n1_q[21], n1_q[20:0]};
        endcase
    end

    // stage 2: rounding
    always_comb begin
        n2_t = '0;
        for (int k = 0; k < 12; k++) begin
            n2_t    = rnd30(72'(r1_p[k]));
            n2_r[k] = n2_t[RW-1:0];
        end
    end

    // stage 7: halve with rounding, saturate
    assign n7_hx = (48'(r6_tx) + 48'sd1) >>> 1;
    assign n7_hy = (48'(r6_ty) + 48'sd1) >>> 1;

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r0_co   <= i_data.neg_own ? -i_data.own.x : i_data.own.x;
            r0_so   <= i_data.neg_own ? -i_data.own.y : i_data.own.y;
            r0_cp   <= i_data.neg_par ? -i_data.par.x : i_data.par.x;
            r0_sp   <= i_data.neg_par ? -i_data.par.y : i_data.par.y;
            r0_ct   <= i_data.neg_tot ? -i_data.tot.x : i_data.tot.x;
            r0_st   <= i_data.neg_tot ? -i_data.tot.y : i_data.tot.y;
            r0_px   <= i_data.px;
            r0_py   <= i_data.py;
            r0_ppx  <= i_data.ppx;
            r0_ppy  <= i_data.ppy;
            r0_sx   <= i_data.sx;
            r0_sy   <= i_data.sy;
            r0_psx  <= i_data.psx;
            r0_psy  <= i_data.psy;
            r0_zm   <= i_data.zm;
            r0_zsat <= i_data.zsat;
            r0_q0   <= n0_qp[54:32];
        end
        if (ld[1]) begin
            r1_p   <= n1_p;
            r1_cp  <= r0_cp;
            r1_sp  <= r0_sp;
            r1_px  <= r0_px;
            r1_py  <= r0_py;
            r1_ppx <= r0_ppx;
            r1_ppy <= r0_ppy;
            r1_sx  <= r0_sx;
            r1_sy  <= r0_sy;
            r1_psx <= r0_psx;
            r1_psy <= r0_psy;
            r1_z   <= n1_z;
        end
        if (ld[2]) begin
            r2_r   <= n2_r;
            r2_cp  <= r1_cp;
            r2_sp  <= r1_sp;
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r2_ppx <= r1_ppx;
            r2_ppy <= r1_ppy;
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_psx <= r1_psx;
            r2_psy <= r1_psy;
            r2_z   <= r1_z;
        end
        if (ld[3]) begin
            r3_m00 <= sat32(48'(r2_r[0]));
            r3_m10 <= sat32(48'(r2_r[1]));
            r3_m01 <= sat32(-48'(r2_r[2]));
            r3_m11 <= sat32(48'(r2_r[3]));
            // doubled units: 2*pos + size - R*size
            r3_vx  <= (VW'(r2_px) <<< 1) + $signed({6'b0, r2_sx})
                      - (VW'(r2_r[4]) - VW'(r2_r[5]));
            r3_vy  <= (VW'(r2_py) <<< 1) + $signed({6'b0, r2_sy})
                      - (VW'(r2_r[6]) + VW'(r2_r[7]));
            r3_wx  <= (VW'(r2_ppx) <<< 1) + $signed({6'b0, r2_psx})
                      - (VW'(r2_r[8]) - VW'(r2_r[9]));
            r3_wy  <= (VW'(r2_ppy) <<< 1) + $signed({6'b0, r2_psy})
                      - (VW'(r2_r[10]) + VW'(r2_r[11]));
            r3_cp  <= r2_cp;
            r3_sp  <= r2_sp;
            r3_z   <= r2_z;
        end
        if (ld[4]) begin
            // v = vh*2^15 + vl, vl unsigned
            r4_hi[0] <= r3_cp * $signed(r3_vx[VW-1:15]);
            r4_lo[0] <= r3_cp * $signed({1'b0, r3_vx[14:0]});
            r4_hi[1] <= r3_sp * $signed(r3_vy[VW-1:15]);
            r4_lo[1] <= r3_sp * $signed({1'b0, r3_vy[14:0]});
            r4_hi[2] <= r3_sp * $signed(r3_vx[VW-1:15]);
            r4_lo[2] <= r3_sp * $signed({1'b0, r3_vx[14:0]});
            r4_hi[3] <= r3_cp * $signed(r3_vy[VW-1:15]);
            r4_lo[3] <= r3_cp * $signed({1'b0, r3_vy[14:0]});
            r4_wx    <= r3_wx;
            r4_wy    <= r3_wy;
            r4_m00   <= r3_m00;
            r4_m10   <= r3_m10;
            r4_m01   <= r3_m01;
            r4_m11   <= r3_m11;
            r4_z     <= r3_z;
        end
        if (ld[5]) begin
            for (int k = 0; k < 4; k++) begin
                r5_t[k] <= rnd30((72'(r4_hi[k]) <<< 15) + 72'(r4_lo[k]));
            end
            r5_wx  <= r4_wx;
            r5_wy  <= r4_wy;
            r5_m00 <= r4_m00;
            r5_m10 <= r4_m10;
            r5_m01 <= r4_m01;
            r5_m11 <= r4_m11;
            r5_z   <= r4_z;
        end
        if (ld[6]) begin
            r6_tx  <= TW'(r5_t[0]) - TW'(r5_t[1]) + TW'(r5_wx);
            r6_ty  <= TW'(r5_t[2]) + TW'(r5_t[3]) + TW'(r5_wy);
            r6_m00 <= r5_m00;
            r6_m10 <= r5_m10;
            r6_m01 <= r5_m01;
            r6_m11 <= r5_m11;
            r6_z   <= r5_z;
        end
        if (ld[7]) begin
            r7_tx  <= sat32(n7_hx);
            r7_ty  <= sat32(n7_hy);
            r7_m00 <= r6_m00;
            r7_m10 <= r6_m10;
            r7_m01 <= r6_m01;
            r7_m11 <= r6_m11;
            r7_z   <= r6_z;
        end
    end

    assign o_m00     = r7_m00;
    assign o_m10     = r7_m10;
    assign o_m01     = r7_m01;
    assign o_m11     = r7_m11;
    assign o_trans_x = r7_tx;
    assign o_trans_y = r7_ty;
    assign o_trans_z = r7_z;

endmodule
